[rtl/shamh_pkg.sv]
// Shared types, constants and round functions for the SHA-256 message hasher.
// Used by shamh_ctrl, shamh_datapath and sha256_message_hasher_unit.
`default_nettype none

package shamh_pkg;

    localparam int WORD_W  = 32;
    localparam int FILL_W  = 6;
    localparam int COUNT_W = 29;
    localparam int ROUND_W = 6;
    localparam int INDEX_W = 3;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [WORD_W-1:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WORD_W-1:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic put_byte;
        logic pad_word;
        logic zero_word;
        logic len_word;
        logic comp_init;
        logic comp_round;
        logic comp_fin;
        logic out_step;
        logic msg_clear;
    } shamh_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic              round_last;
        logic              out_last;
    } shamh_stat_t;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                               input int n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

[rtl/sha256_message_hasher_unit.sv]
// SHA-256 message hasher, top level: stream ports around the controller and
// datapath. Depends on shamh_pkg, shamh_ctrl and shamh_datapath.
//
// Usage: message bytes enter on the s_ channel, one per word. s_tuser marks
// whether s_tdata carries a byte; s_tlast ends the message, and a word with
// s_tlast and no byte finishes the message without adding one (empty message
// allowed). The digest leaves on the m_ channel as eight 32-bit words, most
// significant first, with m_tuser giving the word index and m_tlast on the
// eighth.
// Flow: a byte that does not complete a block leaves the unit ready for the
// next word. The 64th byte of a block starts a compression (load, 64 rounds
// through the single round unit, chain update) before the next word is taken.
// After the final word the padding words go into the schedule, each padding
// block is compressed, and the digest is offered after the last one; a second
// padding block is needed when the length does not fit in the first.
// Each digest word waits as long as m_tready is low.
// s_tready is low during each compression and from the final word until the
// eighth digest word is taken.
// Reset (aresetn low, synchronous) loads the initial hash, empties the
// block and clears the byte count; the same happens after the eighth word.
`default_nettype none

module sha256_message_hasher_unit
    import shamh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_tuser,   // [0] byte_valid
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] digest_word
    output logic [2:0]       m_tuser,   // [2:0] word_index
    output logic             m_tlast    // last_word
);

    shamh_cmd_t  cmd;
    shamh_stat_t stat;
    logic        in_fire;
    logic        out_fire;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign m_tlast  = stat.out_last;

    shamh_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_fire       (in_fire),
        .in_byte_valid (s_tuser[0]),
        .in_last       (s_tlast),
        .out_fire      (out_fire),
        .in_ready      (s_tready),
        .out_valid     (m_tvalid),
        .cmd           (cmd),
        .stat          (stat)
    );

    shamh_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .data_byte   (s_tdata),
        .stat        (stat),
        .digest_word (m_tdata),
        .word_index  (m_tuser)
    );

endmodule

`default_nettype wire

[rtl/shamh_ctrl.sv]
// Sequencing state machine of the SHA-256 message hasher: byte intake,
// padding, compression rounds and digest readout. Depends on shamh_pkg.
`default_nettype none

module shamh_ctrl
    import shamh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_fire,
    input  wire logic        in_byte_valid,
    input  wire logic        in_last,
    input  wire logic        out_fire,
    output logic             in_ready,
    output logic             out_valid,
    output shamh_cmd_t       cmd,
    input  wire shamh_stat_t stat
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_PAD    = 4'd1;
    localparam logic [3:0] ST_ZERO   = 4'd2;
    localparam logic [3:0] ST_LEN_HI = 4'd3;
    localparam logic [3:0] ST_LEN_LO = 4'd4;
    localparam logic [3:0] ST_CINIT  = 4'd5;
    localparam logic [3:0] ST_ROUND  = 4'd6;
    localparam logic [3:0] ST_CFIN   = 4'd7;
    localparam logic [3:0] ST_DIGEST = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       last_pend_reg, last_pend_next;
    logic       pad_done_reg, pad_done_next;
    logic       len_done_reg, len_done_next;
    logic       extra_reg, extra_next;
    logic [3:0] word_cnt;

    assign word_cnt  = stat.fill[FILL_W-1:2];
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_DIGEST);

    always_comb begin
        state_next     = state_reg;
        last_pend_next = last_pend_reg;
        pad_done_next  = pad_done_reg;
        len_done_next  = len_done_reg;
        extra_next     = extra_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    cmd.put_byte   = in_byte_valid;
                    last_pend_next = in_last;
                    if (in_byte_valid && stat.fill == {FILL_W{1'b1}}) begin
                        state_next = ST_CINIT;
                    end else if (in_last) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                // Too little room for the length means a second padding block.
                cmd.pad_word  = 1'b1;
                pad_done_next = 1'b1;
                extra_next    = (stat.fill >= 6'd56);
                state_next    = (word_cnt == 4'd15) ? ST_CINIT : ST_ZERO;
            end
            ST_ZERO: begin
                if (word_cnt == 4'd14 && !extra_reg) begin
                    state_next = ST_LEN_HI;
                end else begin
                    cmd.zero_word = 1'b1;
                    if (word_cnt == 4'd15) begin
                        state_next = ST_CINIT;
                    end
                end
            end
            ST_LEN_HI: begin
                cmd.zero_word = 1'b1;
                state_next    = ST_LEN_LO;
            end
            ST_LEN_LO: begin
                cmd.len_word  = 1'b1;
                len_done_next = 1'b1;
                state_next    = ST_CINIT;
            end
            ST_CINIT: begin
                cmd.comp_init = 1'b1;
                state_next    = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.comp_round = 1'b1;
                if (stat.round_last) begin
                    state_next = ST_CFIN;
                end
            end
            ST_CFIN: begin
                cmd.comp_fin = 1'b1;
                extra_next   = 1'b0;
                priority if (len_done_reg) begin
                    state_next = ST_DIGEST;
                end else if (pad_done_reg) begin
                    state_next = ST_ZERO;
                end else if (last_pend_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIGEST: begin
                if (out_fire) begin
                    cmd.out_step = 1'b1;
                    if (stat.out_last) begin
                        cmd.msg_clear  = 1'b1;
                        last_pend_next = 1'b0;
                        pad_done_next  = 1'b0;
                        len_done_next  = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            last_pend_reg <= 1'b0;
            pad_done_reg  <= 1'b0;
            len_done_reg  <= 1'b0;
            extra_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            last_pend_reg <= last_pend_next;
            pad_done_reg  <= pad_done_next;
            len_done_reg  <= len_done_next;
            extra_reg     <= extra_next;
        end
    end

    // Intake and readout never overlap.
    assert property (@(posedge aclk) disable iff (!aresetn) !(in_ready && out_valid))
        else $error("input ready while digest is shown");

    // A compression only starts on a block boundary.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CINIT |-> stat.fill == '0)
        else $error("compression started on a partial block");

    // The last round hands over to the chain update.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ROUND && stat.round_last |=> state_reg == ST_CFIN)
        else $error("round sequence overran");

    // The eighth digest word returns the block to intake.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_fire && stat.out_last |=> state_reg == ST_IDLE && stat.fill == '0)
        else $error("message state not cleared after digest");

endmodule

`default_nettype wire

[rtl/shamh_datapath.sv]
// Datapath of the SHA-256 message hasher: byte packing, message schedule
// shift line, round unit and chaining registers. Depends on shamh_pkg.
`default_nettype none

module shamh_datapath
    import shamh_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire shamh_cmd_t         cmd,
    input  wire logic [7:0]         data_byte,
    output shamh_stat_t             stat,
    output logic [WORD_W-1:0]       digest_word,
    output logic [INDEX_W-1:0]      word_index
);

    logic [WORD_W-1:0]  chain_reg [8];
    logic [WORD_W-1:0]  work_reg  [8];
    logic [WORD_W-1:0]  sched_reg [16];
    logic [WORD_W-1:0]  acc_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [ROUND_W-1:0] round_reg;
    logic [INDEX_W-1:0] out_idx_reg;

    logic [1:0]        byte_off;
    logic [7:0]        byte_in;
    logic [WORD_W-1:0] byte_word;
    logic [WORD_W-1:0] acc_next;
    logic              push;
    logic [WORD_W-1:0] push_word;
    logic [WORD_W-1:0] sched_new;
    logic [WORD_W-1:0] t1;
    logic [WORD_W-1:0] t2;

    assign byte_off  = fill_reg[1:0];
    assign byte_in   = cmd.pad_word ? PAD_BYTE : data_byte;
    assign byte_word = {byte_in, 24'h0} >> {byte_off, 3'b000};
    // A word starts from zero at its first byte, so padding bytes read as zero.
    assign acc_next  = ((byte_off == 2'd0) ? '0 : acc_reg) | byte_word;

    assign push = cmd.pad_word || cmd.zero_word || cmd.len_word
               || (cmd.put_byte && byte_off == 2'd3);

    always_comb begin
        push_word = '0;
        if (cmd.len_word) begin
            push_word = {count_reg, 3'b000};
        end else if (cmd.put_byte || cmd.pad_word) begin
            push_word = acc_next;
        end
    end

    assign sched_new = small_sigma1(sched_reg[14]) + sched_reg[9]
                     + small_sigma0(sched_reg[1]) + sched_reg[0];

    assign t1 = work_reg[7] + big_sigma1(work_reg[4])
              + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
              + ROUND_K[round_reg] + sched_reg[0];
    assign t2 = big_sigma0(work_reg[0])
              + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                 ^ (work_reg[1] & work_reg[2]));

    // Message words and schedule words shift in at the top; round t reads word 0.
    always_ff @(posedge aclk) begin
        if (cmd.put_byte) begin
            acc_reg <= acc_next;
        end
        if (push || cmd.comp_round) begin
            for (int i = 0; i < 15; i++) begin
                sched_reg[i] <= sched_reg[i+1];
            end
            sched_reg[15] <= cmd.comp_round ? sched_new : push_word;
        end
        if (cmd.comp_init) begin
            for (int i = 0; i < 8; i++) begin
                work_reg[i] <= chain_reg[i];
            end
        end else if (cmd.comp_round) begin
            work_reg[0] <= t1 + t2;
            work_reg[1] <= work_reg[0];
            work_reg[2] <= work_reg[1];
            work_reg[3] <= work_reg[2];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[5] <= work_reg[4];
            work_reg[6] <= work_reg[5];
            work_reg[7] <= work_reg[6];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.msg_clear) begin
            for (int i = 0; i < 8; i++) begin
                chain_reg[i] <= INIT_HASH[i];
            end
            fill_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (cmd.comp_fin) begin
                for (int i = 0; i < 8; i++) begin
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
                end
            end
            if (cmd.put_byte) begin
                fill_reg  <= fill_reg + 1'b1;
                count_reg <= count_reg + 1'b1;
            end else if (push) begin
                fill_reg <= {fill_reg[FILL_W-1:2] + 1'b1, 2'b00};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            round_reg   <= '0;
            out_idx_reg <= '0;
        end else begin
            if (cmd.comp_init) begin
                round_reg <= '0;
            end else if (cmd.comp_round) begin
                round_reg <= round_reg + 1'b1;
            end
            if (cmd.msg_clear) begin
                out_idx_reg <= '0;
            end else if (cmd.out_step) begin
                out_idx_reg <= out_idx_reg + 1'b1;
            end
        end
    end

    assign stat.fill       = fill_reg;
    assign stat.round_last = (round_reg == {ROUND_W{1'b1}});
    assign stat.out_last   = (out_idx_reg == {INDEX_W{1'b1}});

    assign digest_word = chain_reg[out_idx_reg];
    assign word_index  = out_idx_reg;

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for sha256_message_hasher_unit: byte streams in, digest words out.
// Holds its own SHA-256 predictor and needs only the RTL (shamh_pkg and the unit's sources).
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic [0:0]  s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // Predictor state.
    logic [31:0] hash_state [8];
    logic [31:0] block_words [16];
    int unsigned block_fill_cnt;
    logic [28:0] msg_bytes;

    digest_word_t digest_q [$];
    digest_word_t want_word;

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_req      = 0;
    int hold_left     = 0;
    int error_count   = 0;
    int items_sent    = 0;
    int bytes_sent    = 0;
    int msgs_hashed   = 0;
    int words_checked = 0;

    sha256_message_hasher_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void clear_hash_state();
        for (int i = 0; i < 8; i++) hash_state[i] = SHA_IV[i];
        for (int i = 0; i < 16; i++) block_words[i] = '0;
        block_fill_cnt = 0;
        msg_bytes = '0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int t = 0; t < 16; t++) w[t] = block_words[t];
        for (int t = 16; t < 64; t++)
            w[t] = (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                 + (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
        for (int i = 0; i < 16; i++) block_words[i] = '0;
        block_fill_cnt = 0;
    endfunction

    // Bytes land big-endian within each schedule word.
    function automatic void place_byte(input logic [7:0] b);
        int unsigned sh;
        sh = (3 - (block_fill_cnt % 4)) * 8;
        block_words[block_fill_cnt / 4][sh +: 8] = b;
        block_fill_cnt = (block_fill_cnt + 1) % 64;
    endfunction

    function automatic void absorb_word(input logic [7:0] b, input logic has_byte,
                                        input logic fin);
        logic extra;
        digest_word_t dw;
        if (has_byte) begin
            place_byte(b);
            msg_bytes = msg_bytes + 1'b1;
            if (block_fill_cnt == 0) compress_block();
        end
        if (fin) begin
            // Fewer than nine free bytes means the length spills into a second block.
            extra = (block_fill_cnt >= 56);
            place_byte(PAD_MARK);
            if (extra) compress_block();
            block_words[14] = '0;
            block_words[15] = {msg_bytes, 3'b000};
            compress_block();
            for (int k = 0; k < 8; k++) begin
                dw.word  = hash_state[k];
                dw.index = 3'(k);
                dw.last  = (k == 7);
                digest_q.push_back(dw);
            end
            msgs_hashed++;
            clear_hash_state();
        end
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < 20) $display("MISMATCH at %0t: %s", $time, what);
        error_count++;
    endtask

    task automatic send_word(input logic [7:0] b, input logic has_byte, input logic fin);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= has_byte;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (has_byte) bytes_sent++;
        absorb_word(b, has_byte, fin);
    endtask

    // A message of n random bytes, closed on its last byte or by a bare finish word.
    // Idle words with random data are scattered in between.
    task automatic send_message(input int unsigned n, input bit bare_end);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(15) == 0) send_word(8'($urandom), 1'b0, 1'b0);
            send_word(8'($urandom), 1'b1, (i == n - 1) && !bare_end);
        end
        if (bare_end || n == 0) send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic wait_digests_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (digest_q.size() != 0) @(posedge aclk);
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (digest_q.size() == 0)
                report_mismatch($sformatf("digest word %h with nothing pending", m_tdata));
            else begin
                want_word = digest_q.pop_front();
                words_checked++;
                if (m_tdata !== want_word.word)
                    report_mismatch($sformatf("word %0d: got %h, want %h",
                                              want_word.index, m_tdata, want_word.word));
                if (m_tuser !== want_word.index)
                    report_mismatch($sformatf("index: got %0d, want %0d",
                                              m_tuser, want_word.index));
                if (m_tlast !== want_word.last)
                    report_mismatch($sformatf("word %0d: last flag %b, want %b",
                                              want_word.index, m_tlast, want_word.last));
            end
        end
    end

    task automatic test_directed();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        send_word(8'hff, 1'b0, 1'b0);          // idle word alone
        send_word(8'ha5, 1'b0, 1'b1);          // empty message
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);          // "abc", finish on the last byte
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hff, 1'b1, 1'b1);
        send_word(8'h55, 1'b1, 1'b0);
        send_word(8'haa, 1'b0, 1'b0);
        send_word(8'haa, 1'b1, 1'b0);
        send_word(8'hff, 1'b0, 1'b1);          // bare finish after bytes
        wait_digests_drained();
    endtask

    // Lengths where the length field spills into a second block, and where the
    // final byte closes a block.
    task automatic test_pad_boundary();
        src_idle_pct  = 10;
        snk_stall_pct = 10;
        send_message(56, 1'b1);
        send_message(64, 1'b0);
        wait_digests_drained();
    endtask

    // The receiver holds off while a second message is offered, so the input stalls.
    task automatic test_backpressure();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_req = 300;
        send_message(4, 1'b0);
        send_message(3, 1'b1);
        while (hold_req != 0 || hold_left != 0) @(posedge aclk);
        wait_digests_drained();
    endtask

    task automatic test_random_phase(input int src_pct, input int snk_pct, input int n_items);
        int start;
        int unsigned len;
        start = items_sent;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        while (items_sent - start < n_items) begin
            if ($urandom_range(7) == 0) begin
                case ($urandom_range(5))
                    0: len = 55;
                    1: len = 56;
                    2: len = 63;
                    3: len = 64;
                    4: len = 119;
                    default: len = 120;
                endcase
            end else
                len = $urandom_range(20);
            send_message(len, $urandom_range(2) == 0);
        end
        wait_digests_drained();
    endtask

    initial begin
        #1_000_000;
        $display("sha256_message_hasher_unit verification failed");
        $finish;
    end

    initial begin
        clear_hash_state();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_pad_boundary();
        test_backpressure();
        test_random_phase(0, 0, 25);
        test_random_phase(47, 0, 25);
        test_random_phase(0, 47, 25);
        test_random_phase(28, 28, 25);
        repeat (200) @(posedge aclk);
        $display("Hashed %0d messages from %0d bytes in %0d input words; %0d digest words checked.",
                 msgs_hashed, bytes_sent, items_sent, words_checked);
        $display("Covered empty messages, bare finishes, idle words, padding edges and stalls.");
        if (error_count == 0)
            $display("sha256_message_hasher_unit verification clean");
        else
            $display("sha256_message_hasher_unit verification failed");
        $finish;
    end

endmodule

`default_nettype wire
